>>> design/hpp_pkg.sv
// Package for the haptic pattern priority player.
// Holds command and status codes, queue entry and cell types, and the step table.
// No dependencies.
package hpp_pkg;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_REQUEST = 2'd1;
    localparam logic [1:0] CMD_STOP    = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REJECTED = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    localparam logic [2:0] PATTERN_FIRST = 3'd1;
    localparam logic [2:0] PATTERN_LAST  = 3'd5;
    localparam logic [2:0] PATTERN_DUAL  = 3'd5;

    typedef struct packed {
        logic [1:0] prio;
        logic [2:0] pattern;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_SHIFT  = 2'd1,
        CELL_INSERT = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic [8:0]  freq;
        logic [15:0] duty;
        logic [6:0]  on_ms;
        logic [6:0]  off_ms;
    } step_t;

    typedef struct packed {
        logic       tick;
        logic       stop;
        logic       req_ok;
        logic [1:0] req_prio;
        logic       head_valid;
        entry_t     head;
    } player_ctl_t;

    typedef struct packed {
        logic        start;
        logic        active;
        logic [1:0]  prio;
        logic        pwm_on;
        logic [8:0]  freq;
        logic [15:0] duty;
    } player_stat_t;

    function automatic logic [2:0] pat_first(input logic [2:0] pat);
        logic [2:0] f;
        case (pat)
            3'd2:    f = 3'd1;
            3'd3:    f = 3'd3;
            3'd4:    f = 3'd6;
            3'd5:    f = 3'd7;
            default: f = 3'd0;
        endcase
        return f;
    endfunction

    function automatic logic [1:0] pat_count(input logic [2:0] pat);
        logic [1:0] c;
        case (pat)
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd3;
            3'd4:    c = 2'd1;
            3'd5:    c = 2'd2;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic step_t step_of(input logic [2:0] pat, input logic [1:0] idx);
        logic [2:0] k;
        step_t      s;
        k = pat_first(pat) + {1'b0, idx};
        case (k)
            3'd0:    s = '{freq: 9'd250, duty: 16'd39321, on_ms: 7'd50,  off_ms: 7'd0};
            3'd1:    s = '{freq: 9'd250, duty: 16'd45874, on_ms: 7'd50,  off_ms: 7'd50};
            3'd2:    s = '{freq: 9'd250, duty: 16'd45874, on_ms: 7'd50,  off_ms: 7'd0};
            3'd3:    s = '{freq: 9'd250, duty: 16'd52428, on_ms: 7'd50,  off_ms: 7'd50};
            3'd4:    s = '{freq: 9'd250, duty: 16'd52428, on_ms: 7'd50,  off_ms: 7'd50};
            3'd5:    s = '{freq: 9'd250, duty: 16'd52428, on_ms: 7'd50,  off_ms: 7'd0};
            3'd6:    s = '{freq: 9'd250, duty: 16'd65535, on_ms: 7'd100, off_ms: 7'd0};
            default: s = '{freq: 9'd320, duty: 16'd65535, on_ms: 7'd50,  off_ms: 7'd50};
        endcase
        if (pat == PATTERN_DUAL && idx == 2'd1)
        begin
            s = '{freq: 9'd170, duty: 16'd26214, on_ms: 7'd50, off_ms: 7'd0};
        end
        return s;
    endfunction

endpackage

>>> design/hpp_if.sv
// Channel interfaces for the haptic pattern priority player.
// Depends on nothing; payload widths follow the command and result fields.
interface hpp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [2:0] pattern_id;
    logic [1:0] priority_req;

    modport source (output valid, output command, output pattern_id, output priority_req,
                    input ready);
    modport sink (input valid, input command, input pattern_id, input priority_req,
                  output ready);
endinterface

interface hpp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        pwm_on;
    logic [8:0]  pwm_freq_hz;
    logic [15:0] pwm_duty;
    logic [3:0]  queue_count;
    logic        playing;
    logic [1:0]  playing_priority;

    modport source (output valid, output status, output pwm_on, output pwm_freq_hz,
                    output pwm_duty, output queue_count, output playing,
                    output playing_priority, input ready);
    modport sink (input valid, input status, input pwm_on, input pwm_freq_hz,
                  input pwm_duty, input queue_count, input playing,
                  input playing_priority, output ready);
endinterface

>>> design/hpp_cell.sv
// One cell of the priority queue chain: holds one entry.
// Depends on hpp_pkg for entry and operation types.
module hpp_cell (
    input  logic              clk,
    input  hpp_pkg::cell_op_t op,
    input  hpp_pkg::entry_t   new_entry,
    input  logic              left_ge,
    input  hpp_pkg::entry_t   left_entry,
    input  hpp_pkg::entry_t   right_entry,
    input  logic              occupied,
    output hpp_pkg::entry_t   entry,
    output logic              ge
);

    hpp_pkg::entry_t entry_reg;
    hpp_pkg::entry_t entry_next;

    assign ge    = occupied && (entry_reg.prio >= new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (op)
            hpp_pkg::CELL_SHIFT:  entry_next = right_entry;
            hpp_pkg::CELL_INSERT:
            begin
                if (!ge)
                begin
                    entry_next = left_ge ? new_entry : left_entry;
                end
            end
            default:              entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> design/hpp_player.sv
// Playback sequencer: steps through the on and off phases of the active pattern.
// Depends on hpp_pkg for the step table and the control and status structs.
module hpp_player (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hpp_pkg::player_ctl_t  ctl,
    output hpp_pkg::player_stat_t stat
);

    logic       active_reg,  active_next;
    logic [1:0] prio_reg,    prio_next;
    logic [2:0] pattern_reg, pattern_next;
    logic [1:0] idx_reg,     idx_next;
    logic       off_reg,     off_next;
    logic [6:0] rem_reg,     rem_next;
    logic       abort_reg,   abort_next;
    logic       start;

    hpp_pkg::step_t s_cur;
    hpp_pkg::step_t s_adv;
    hpp_pkg::step_t s_head;
    hpp_pkg::step_t s_out;
    logic [6:0]     rem_dec;
    logic           last_step;

    assign s_cur     = hpp_pkg::step_of(pattern_reg, idx_reg);
    assign s_adv     = hpp_pkg::step_of(pattern_reg, idx_reg + 2'd1);
    assign s_head    = hpp_pkg::step_of(ctl.head.pattern, 2'd0);
    assign rem_dec   = (rem_reg != 7'd0) ? rem_reg - 7'd1 : 7'd0;
    assign last_step = ({1'b0, idx_reg} + 3'd1) >= {1'b0, hpp_pkg::pat_count(pattern_reg)};

    always_comb
    begin
        active_next  = active_reg;
        prio_next    = prio_reg;
        pattern_next = pattern_reg;
        idx_next     = idx_reg;
        off_next     = off_reg;
        rem_next     = rem_reg;
        abort_next   = abort_reg;
        start        = 1'b0;
        if (ctl.tick)
        begin
            if (active_reg)
            begin
                if (abort_reg)
                begin
                    active_next  = 1'b0;
                    prio_next    = 2'd0;
                    pattern_next = 3'd0;
                    idx_next     = 2'd0;
                    off_next     = 1'b0;
                    rem_next     = 7'd0;
                end
                else
                begin
                    rem_next = rem_dec;
                    if (rem_dec == 7'd0)
                    begin
                        if (!off_reg && s_cur.off_ms != 7'd0)
                        begin
                            off_next = 1'b1;
                            rem_next = s_cur.off_ms;
                        end
                        else if (last_step)
                        begin
                            active_next  = 1'b0;
                            prio_next    = 2'd0;
                            pattern_next = 3'd0;
                            idx_next     = 2'd0;
                            off_next     = 1'b0;
                            rem_next     = 7'd0;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                            off_next = 1'b0;
                            rem_next = s_adv.on_ms;
                        end
                    end
                end
            end
            if (!active_next && ctl.head_valid)
            begin
                start        = 1'b1;
                active_next  = 1'b1;
                prio_next    = ctl.head.prio;
                pattern_next = ctl.head.pattern;
                idx_next     = 2'd0;
                off_next     = 1'b0;
                abort_next   = 1'b0;
                rem_next     = s_head.on_ms;
            end
        end
        else if (ctl.stop)
        begin
            abort_next = 1'b1;
        end
        else if (ctl.req_ok && active_reg && ctl.req_prio > prio_reg)
        begin
            abort_next = 1'b1;
        end
    end

    assign s_out = hpp_pkg::step_of(pattern_next, idx_next);

    always_comb
    begin
        stat.start  = start;
        stat.active = active_next;
        stat.prio   = prio_next;
        stat.pwm_on = active_next && !off_next;
        stat.freq   = stat.pwm_on ? s_out.freq : 9'd0;
        stat.duty   = stat.pwm_on ? s_out.duty : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            prio_reg    <= 2'd0;
            pattern_reg <= 3'd0;
            idx_reg     <= 2'd0;
            off_reg     <= 1'b0;
            rem_reg     <= 7'd0;
            abort_reg   <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            prio_reg    <= prio_next;
            pattern_reg <= pattern_next;
            idx_reg     <= idx_next;
            off_reg     <= off_next;
            rem_reg     <= rem_next;
            abort_reg   <= abort_next;
        end
    end

endmodule

>>> design/haptic_pattern_priority_player.sv
// Top level of the haptic pattern priority player: queue cell chain, player, result register.
// Depends on hpp_pkg, hpp_if, hpp_cell and hpp_player.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------------
//   in_ch    | in  | valid/ready   | command, pattern_id, priority_req
//   out_ch   | out | valid/ready   | status, pwm_on, pwm_freq_hz, pwm_duty,
//            |     |               | queue_count, playing, playing_priority
//   cfg      | in  | cfg_we        | cfg_wdata (motor_enabled)
//
// One command per cycle while out_ch is not stalled: each transfer on in_ch updates
// the queue cells and the player and loads the result register at the same edge.
// in_ch is ready whenever the result register is empty or is being taken.
// Reset clears the queue length, the player state and the result valid flag;
// queue cells hold their contents and are read only below the queue length.
module haptic_pattern_priority_player #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    hpp_in_if.sink           in_ch,
    hpp_out_if.source        out_ch
);

    localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

    logic             enabled_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             xfer;
    logic             out_valid_reg;
    logic             req;
    logic             full;
    logic [1:0]       status;

    hpp_pkg::entry_t       new_entry;
    hpp_pkg::entry_t       cell_q [QUEUE_DEPTH];
    logic                  cell_ge [QUEUE_DEPTH];
    hpp_pkg::cell_op_t     op;
    hpp_pkg::player_ctl_t  ctl;
    hpp_pkg::player_stat_t stat;
    logic [LEN_W+3:0]      len_ext;

    logic [1:0]  status_reg;
    logic        pwm_on_reg;
    logic [8:0]  freq_reg;
    logic [15:0] duty_reg;
    logic [3:0]  count_reg;
    logic        playing_reg;
    logic [1:0]  pprio_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign xfer        = in_ch.valid && in_ch.ready;
    assign req         = in_ch.command == hpp_pkg::CMD_REQUEST;
    assign full        = len_reg >= LEN_W'(QUEUE_DEPTH);

    always_comb
    begin
        status = hpp_pkg::STATUS_OK;
        if (req)
        begin
            if (!enabled_reg
                || !(in_ch.pattern_id inside {[hpp_pkg::PATTERN_FIRST:hpp_pkg::PATTERN_LAST]}))
            begin
                status = hpp_pkg::STATUS_REJECTED;
            end
            else if (full)
            begin
                status = hpp_pkg::STATUS_FULL;
            end
        end
    end

    assign new_entry.prio    = in_ch.priority_req;
    assign new_entry.pattern = in_ch.pattern_id;

    always_comb
    begin
        ctl.tick       = xfer && in_ch.command == hpp_pkg::CMD_TICK;
        ctl.stop       = xfer && in_ch.command == hpp_pkg::CMD_STOP;
        ctl.req_ok     = xfer && req && status == hpp_pkg::STATUS_OK;
        ctl.req_prio   = in_ch.priority_req;
        ctl.head_valid = len_reg != '0;
        ctl.head       = cell_q[0];
    end

    hpp_player u_player (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat)
    );

    always_comb
    begin
        op       = hpp_pkg::CELL_HOLD;
        len_next = len_reg;
        if (stat.start)
        begin
            op       = hpp_pkg::CELL_SHIFT;
            len_next = len_reg - LEN_W'(1);
        end
        else if (ctl.req_ok)
        begin
            op       = hpp_pkg::CELL_INSERT;
            len_next = len_reg + LEN_W'(1);
        end
        else if (ctl.stop)
        begin
            len_next = '0;
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic            left_ge;
        hpp_pkg::entry_t left_entry;
        hpp_pkg::entry_t right_entry;

        if (i == 0)
        begin : g_first
            assign left_ge    = 1'b1;
            assign left_entry = new_entry;
        end
        else
        begin : g_mid
            assign left_ge    = cell_ge[i-1];
            assign left_entry = cell_q[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_inner
            assign right_entry = cell_q[i+1];
        end

        hpp_cell u_cell (
            .clk         (clk),
            .op          (op),
            .new_entry   (new_entry),
            .left_ge     (left_ge),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .occupied    (len_reg > LEN_W'(i)),
            .entry       (cell_q[i]),
            .ge          (cell_ge[i])
        );
    end

    assign len_ext = {4'b0000, len_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                enabled_reg <= cfg_wdata;
            end
            if (xfer)
            begin
                len_reg <= len_next;
            end
            if (xfer)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            status_reg  <= status;
            pwm_on_reg  <= stat.pwm_on;
            freq_reg    <= stat.freq;
            duty_reg    <= stat.duty;
            count_reg   <= len_ext[3:0];
            playing_reg <= stat.active;
            pprio_reg   <= stat.prio;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.status           = status_reg;
    assign out_ch.pwm_on           = pwm_on_reg;
    assign out_ch.pwm_freq_hz      = freq_reg;
    assign out_ch.pwm_duty         = duty_reg;
    assign out_ch.queue_count      = count_reg;
    assign out_ch.playing          = playing_reg;
    assign out_ch.playing_priority = pprio_reg;

endmodule
